@@ design/psue_pkg.sv @@
// Package for the particle swarm update engine: sizes, command codes,
// sequencer states and saturation helpers. No dependencies.
`timescale 1ns / 1ps
package psue_pkg;

  localparam int MaxParticles = 32;
  localparam int MaxDims      = 16;
  localparam int PartW        = $clog2(MaxParticles);
  localparam int DimW         = $clog2(MaxDims);
  localparam int AddrW        = PartW + DimW;
  localparam int CoefW        = 18;
  localparam int DimsCfgW     = 5;
  localparam int CfgIdxW      = 3;

  localparam logic [31:0] VelocityOne = 32'sd65536;
  localparam logic signed [53:0] RoundHalf = 54'sd32768;

  typedef enum logic [2:0] {
    CMD_LOAD   = 3'd0,
    CMD_ORIGIN = 3'd1,
    CMD_REPORT = 3'd2,
    CMD_MOVE   = 3'd3,
    CMD_READ   = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    REG_INERTIA   = 3'd0,
    REG_COGNITIVE = 3'd1,
    REG_SOCIAL    = 3'd2,
    REG_DIMS      = 3'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_K1, ST_K2, ST_K3, ST_MRD, ST_M0, ST_M1, ST_M2, ST_M3,
    ST_FIN, ST_CPRD, ST_CPWR, ST_GB
  } state_t;

  // Clip a value to 32-bit signed range, flag when clipped
  function automatic logic [32:0] clip38(input logic signed [37:0] x);
    logic [32:0] r;
    if (x > 38'sh007FFFFFFF) r = {1'b1, 32'h7FFFFFFF};
    else if (x < -38'sh0080000000) r = {1'b1, 32'h80000000};
    else r = {1'b0, x[31:0]};
    return r;
  endfunction

  function automatic logic [32:0] clip33(input logic signed [32:0] x);
    logic [32:0] r;
    if (x[32] != x[31]) r = {1'b1, x[32] ? 32'h80000000 : 32'h7FFFFFFF};
    else r = {1'b0, x[31:0]};
    return r;
  endfunction

endpackage

@@ design/particle_swarm_update_engine_top.sv @@
// Particle swarm update engine: after its transfer a move keeps the input
// stalled through the gain states and, for each of the n dimensions in use,
// the read, multiply and finish states plus output waits, because one shared
// multiplier does the three products of every dimension in turn and the swarm
// memories give one element per cycle. A cost report that improves a best
// copies a row of 16 elements, a global best readout emits n elements plus
// output waits, and a load or an origin ends at the transfer. The block takes
// one command at a time; in_stall is high while it works. Depends on psue_pkg.
`timescale 1ns / 1ps
module particle_swarm_update_engine_top
  import psue_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [CoefW-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           command,
  input  logic [PartW-1:0]     particle,
  input  logic [DimW-1:0]      dimension,
  input  logic signed [31:0]   position_value,
  input  logic signed [31:0]   cost,
  input  logic [15:0]          rand_one,
  input  logic [15:0]          rand_two,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   element_value,
  output logic [DimW-1:0]      element_index,
  output logic                 is_global_best,
  output logic                 saturated,
  output logic                 last
);

  // Configuration registers
  logic [CoefW-1:0]    inertia_weight, cognitive_gain, social_gain;
  logic [DimsCfgW-1:0] dimensions_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      inertia_weight    <= CoefW'(47775);
      cognitive_gain    <= CoefW'(97940);
      social_gain       <= CoefW'(97940);
      dimensions_in_use <= DimsCfgW'(16);
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_INERTIA:   inertia_weight    <= cfg_data;
        REG_COGNITIVE: cognitive_gain    <= cfg_data;
        REG_SOCIAL:    social_gain       <= cfg_data;
        REG_DIMS:      dimensions_in_use <= cfg_data[DimsCfgW-1:0];
        default: ;
      endcase
    end
  end

  // Last dimension index in use
  logic [DimW-1:0] last_dim;
  always_comb begin
    if (dimensions_in_use == '0) last_dim = '0;
    else if (dimensions_in_use > DimsCfgW'(MaxDims)) last_dim = DimW'(MaxDims - 1);
    else last_dim = DimW'(dimensions_in_use - 1'b1);
  end

  state_t state, state_next;
  logic [PartW-1:0]  part;
  logic [DimW-1:0]   idx;
  logic [15:0]       r1, r2;
  logic [CoefW-1:0]  k1, k2;
  logic signed [53:0] prod, acc;
  logic              improved, to_global;

  // Swarm state
  logic signed [31:0] pbest_cost [MaxParticles];
  logic [MaxParticles-1:0] pbest_valid;
  logic signed [31:0] gbest [MaxDims];
  logic signed [31:0] gbest_cost;

  logic accept;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);

  logic out_free;
  assign out_free = !out_valid || !out_stall;

  // Memories: registered read at the current particle and dimension
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic signed [31:0] pos_mem [MaxParticles*MaxDims];
  logic signed [31:0] vel_mem [MaxParticles*MaxDims];
  logic signed [31:0] pb_mem  [MaxParticles*MaxDims];
  logic signed [31:0] rd_pos, rd_vel, rd_pb;
  logic pos_we, vel_we, pb_we;
  logic signed [31:0] pos_wd, vel_wd, pb_wd;

  assign rd_addr = {part, idx};

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[wr_addr] <= pos_wd;
    rd_pos <= pos_mem[rd_addr];
  end
  always_ff @(posedge clk) begin
    if (vel_we) vel_mem[wr_addr] <= vel_wd;
    rd_vel <= vel_mem[rd_addr];
  end
  always_ff @(posedge clk) begin
    if (pb_we) pb_mem[wr_addr] <= pb_wd;
    rd_pb <= pb_mem[rd_addr];
  end

  // Personal best element, zero for a row never copied
  logic signed [31:0] pb_elem, copy_src;
  assign pb_elem  = pbest_valid[part] ? rd_pb : 32'sd0;
  assign copy_src = improved ? rd_pos : pb_elem;

  // Shared multiplier operands
  logic signed [18:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [53:0] mul_p;
  logic signed [32:0] diff_pb, diff_gb;
  assign diff_pb = 33'(pb_elem) - 33'(rd_pos);
  assign diff_gb = 33'(gbest[idx]) - 33'(rd_pos);
  assign mul_p   = 54'(mul_a) * 54'(mul_b);

  // Velocity and position update of one element
  logic signed [37:0] v_wide;
  logic [32:0] v_clip, x_clip;
  assign v_wide = 38'(acc >>> 16);
  assign v_clip = clip38(v_wide);
  assign x_clip = clip33(33'(rd_pos) + 33'($signed(v_clip[31:0])));

  // Report decision, taken at the transfer
  logic rep_better, rep_global;
  logic signed [31:0] rep_cost;
  assign rep_better = cost < pbest_cost[particle];
  assign rep_cost   = rep_better ? cost : pbest_cost[particle];
  assign rep_global = rep_cost < gbest_cost;

  logic out_load, out_gb;
  logic signed [31:0] out_val;
  logic out_sat;

  // Next state and control
  always_comb begin
    state_next = state;
    mul_a = '0;
    mul_b = '0;
    pos_we = 1'b0; vel_we = 1'b0; pb_we = 1'b0;
    pos_wd = x_clip[31:0];
    vel_wd = v_clip[31:0];
    pb_wd  = copy_src;
    wr_addr = rd_addr;
    out_load = 1'b0; out_gb = 1'b0;
    out_val = x_clip[31:0];
    out_sat = v_clip[32] | x_clip[32];
    unique case (state)
      ST_IDLE: begin
        wr_addr = {particle, dimension};
        pos_wd = position_value;
        vel_wd = VelocityOne;
        pb_wd  = 32'sd0;
        if (accept) begin
          priority case (command)
            CMD_LOAD: begin
              pos_we = 1'b1; vel_we = 1'b1; pb_we = 1'b1;
            end
            CMD_REPORT: if (rep_better || rep_global) state_next = ST_CPRD;
            CMD_MOVE:   state_next = ST_K1;
            CMD_READ:   state_next = ST_GB;
            default: ;
          endcase
        end
      end
      ST_K1: begin
        mul_a = 19'({1'b0, cognitive_gain});
        mul_b = 34'({18'b0, r1});
        state_next = ST_K2;
      end
      ST_K2: begin
        mul_a = 19'({1'b0, social_gain});
        mul_b = 34'({18'b0, r2});
        state_next = ST_K3;
      end
      ST_K3: state_next = ST_MRD;
      ST_MRD: state_next = ST_M0;
      ST_M0: begin
        mul_a = 19'({1'b0, inertia_weight});
        mul_b = 34'(rd_vel);
        state_next = ST_M1;
      end
      ST_M1: begin
        mul_a = 19'({1'b0, k1});
        mul_b = 34'(diff_pb);
        state_next = ST_M2;
      end
      ST_M2: begin
        mul_a = 19'({1'b0, k2});
        mul_b = 34'(diff_gb);
        state_next = ST_M3;
      end
      ST_M3: state_next = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          pos_we = 1'b1; vel_we = 1'b1; out_load = 1'b1;
          state_next = (idx == last_dim) ? ST_IDLE : ST_MRD;
        end
      end
      ST_CPRD: state_next = ST_CPWR;
      ST_CPWR: begin
        pb_we = improved;
        state_next = (idx == DimW'(MaxDims - 1)) ? ST_IDLE : ST_CPRD;
      end
      ST_GB: begin
        out_val = gbest[idx];
        out_sat = 1'b0;
        out_gb  = 1'b1;
        if (out_free) begin
          out_load = 1'b1;
          if (idx == last_dim) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Command registers, index counter and accumulator
  always_ff @(posedge clk) begin
    prod <= mul_p;
    if (accept) begin
      part      <= particle;
      r1        <= rand_one;
      r2        <= rand_two;
      idx       <= '0;
      improved  <= rep_better;
      to_global <= rep_global;
    end
    unique case (state)
      ST_K2: k1 <= prod[16 +: CoefW];
      ST_K3: k2 <= prod[16 +: CoefW];
      ST_M1: acc <= prod;
      ST_M2: acc <= acc + prod;
      ST_M3: acc <= acc + prod + RoundHalf;
      ST_FIN, ST_GB: if (out_free) idx <= idx + 1'b1;
      ST_CPWR: idx <= idx + 1'b1;
      default: ;
    endcase
  end

  // Personal and global bests
  always_ff @(posedge clk) begin
    if (accept && command == CMD_ORIGIN) begin
      for (int i = 0; i < MaxParticles; i++) pbest_cost[i] <= cost;
    end else if (accept && command == CMD_REPORT && rep_better) begin
      pbest_cost[particle] <= cost;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pbest_valid <= '0;
      for (int i = 0; i < MaxDims; i++) gbest[i] <= 32'sd0;
    end else begin
      if (state == ST_CPWR && improved) pbest_valid[part] <= 1'b1;
      if (state == ST_CPWR && to_global) gbest[idx] <= copy_src;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && command == CMD_ORIGIN) gbest_cost <= cost;
    else if (accept && command == CMD_REPORT && rep_global) gbest_cost <= rep_cost;
  end

  // Output register: hold while stalled, drop after transfer
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      element_value  <= out_val;
      element_index  <= idx;
      is_global_best <= out_gb;
      saturated      <= out_sat;
      last           <= (idx == last_dim);
    end
  end

endmodule

@@ design/psue_checker.sv @@
// Port checker for the particle swarm update engine, bound to the top level.
// Depends on psue_pkg.
`timescale 1ns / 1ps
module psue_checker
  import psue_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [2:0]  command,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] element_value,
  input logic        is_global_best,
  input logic        saturated
);

  // A move keeps the input side busy after its transfer
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && command == CMD_MOVE |=> in_stall)
    else $error("move did not hold the input side");

  // A readout never reports clipping
  assert property (@(posedge clk) disable iff (rst)
    out_valid && is_global_best |-> !saturated)
    else $error("global best readout flagged as saturated");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(element_value))
    else $error("stalled result changed");

endmodule

bind particle_swarm_update_engine_top psue_checker u_psue_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .command(command), .out_valid(out_valid), .out_stall(out_stall),
  .element_value(element_value), .is_global_best(is_global_best),
  .saturated(saturated)
);

@@ dv/tb_top.sv @@
// Self-checking testbench for the particle swarm update engine.
// Drives commands and register writes, predicts every emitted element and
// compares in order. Depends on psue_pkg and particle_swarm_update_engine_top.
`timescale 1ns / 1ps
module tb_top;
  import psue_pkg::*;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [4:0]         part;
    logic [3:0]         dim;
    logic signed [31:0] pos;
    logic signed [31:0] cst;
    logic [15:0]        r1;
    logic [15:0]        r2;
  } cmd_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [3:0]         index;
    logic               gb;
    logic               sat;
    logic               lst;
  } element_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CoefW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] command = '0;
  logic [PartW-1:0] particle = '0;
  logic [DimW-1:0] dimension = '0;
  logic signed [31:0] position_value = '0;
  logic signed [31:0] cost = '0;
  logic [15:0] rand_one = '0;
  logic [15:0] rand_two = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] element_value;
  logic [DimW-1:0] element_index;
  logic is_global_best;
  logic saturated;
  logic last;

  particle_swarm_update_engine_top dut (.*);

  always #6 clk = ~clk;

  // Predictor state
  logic [17:0] w_gain, c1_gain, c2_gain;
  logic [4:0] dims_reg;
  logic signed [31:0] pos_mem [MaxParticles*MaxDims];
  logic signed [31:0] vel_mem [MaxParticles*MaxDims];
  logic signed [31:0] pbest_mem [MaxParticles*MaxDims];
  logic signed [31:0] pbest_cost [MaxParticles];
  logic signed [31:0] gbest [MaxDims];
  logic signed [31:0] gbest_cost;
  bit loaded [MaxParticles*MaxDims];

  element_t pending_elems [$];
  int errors = 0;
  int cycles = 0;
  bit long_hold = 0;

  function automatic int dims_active();
    if (dims_reg == 0) return 1;
    if (dims_reg > MaxDims) return MaxDims;
    return dims_reg;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x, inout bit f);
    if (x > 64'sh7FFFFFFF) begin
      f = 1;
      return 32'sh7FFFFFFF;
    end
    if (x < -64'sh80000000) begin
      f = 1;
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  function automatic void write_reg(input int idx, input logic [17:0] v);
    case (idx)
      REG_INERTIA:   w_gain = v;
      REG_COGNITIVE: c1_gain = v;
      REG_SOCIAL:    c2_gain = v;
      REG_DIMS:      dims_reg = v[4:0];
      default: ;
    endcase
  endfunction

  // Append one predicted element
  function automatic void queue_elem(input element_t e);
    pending_elems.insert(pending_elems.size(), e);
  endfunction

  // Compute the elements a command produces and update the swarm copy
  function automatic void predict_swarm(input cmd_item_t it);
    int n, a;
    logic signed [63:0] k1, k2, x, acc, v64;
    logic signed [31:0] v, nx;
    bit f;
    element_t e;
    n = dims_active();
    case (it.cmd)
      CMD_ORIGIN: begin
        for (int i = 0; i < MaxParticles; i++) pbest_cost[i] = it.cst;
        gbest_cost = it.cst;
      end
      CMD_READ: begin
        for (int i = 0; i < n; i++) begin
          e = '{gbest[i], i[3:0], 1'b1, 1'b0, i == n - 1};
          queue_elem(e);
        end
      end
      CMD_LOAD: begin
        a = it.part * MaxDims + it.dim;
        pos_mem[a] = it.pos;
        vel_mem[a] = VelocityOne;
        pbest_mem[a] = 0;
        loaded[a] = 1;
      end
      CMD_REPORT: begin
        if (it.cst < pbest_cost[it.part]) begin
          for (int i = 0; i < MaxDims; i++)
            pbest_mem[it.part*MaxDims+i] = pos_mem[it.part*MaxDims+i];
          pbest_cost[it.part] = it.cst;
        end
        if (pbest_cost[it.part] < gbest_cost) begin
          for (int i = 0; i < MaxDims; i++) gbest[i] = pbest_mem[it.part*MaxDims+i];
          gbest_cost = pbest_cost[it.part];
        end
      end
      CMD_MOVE: begin
        k1 = (64'(c1_gain) * 64'(it.r1)) >>> 16;
        k2 = (64'(c2_gain) * 64'(it.r2)) >>> 16;
        for (int i = 0; i < n; i++) begin
          a = it.part * MaxDims + i;
          x = pos_mem[a];
          f = 0;
          acc = 64'(w_gain) * 64'(vel_mem[a]) + k1 * (64'(pbest_mem[a]) - x)
              + k2 * (64'(gbest[i]) - x) + 64'sd32768;
          v64 = acc >>> 16;
          v = sat32(v64, f);
          nx = sat32(x + 64'(v), f);
          vel_mem[a] = v;
          pos_mem[a] = nx;
          e = '{nx, i[3:0], 1'b0, f, i == n - 1};
          queue_elem(e);
        end
      end
      default: ;
    endcase
  endfunction

  // Transfer one command: hold valid until accepted, drop it only on a gap
  task automatic send_cmd(input cmd_item_t it, input bit gap);
    int g;
    g = gap ? $urandom_range(0, 11) : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    command <= it.cmd;
    particle <= it.part;
    dimension <= it.dim;
    position_value <= it.pos;
    cost <= it.cst;
    rand_one <= it.r1;
    rand_two <= it.r2;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_swarm(it);
    @(negedge clk);
  endtask

  // Register write while idle: drain expected output first
  task automatic set_reg(input int idx, input logic [17:0] v);
    in_valid <= 1'b0;
    while (pending_elems.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_index <= idx[CfgIdxW-1:0];
    cfg_data <= v;
    cfg_write <= 1'b1;
    @(posedge clk);
    write_reg(idx, v);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Receiver side: random stalls, one long hold-off
  initial begin
    int s;
    @(negedge clk);
    while (1) begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
        long_hold = 0;
      end
      s = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      out_stall <= (s > 0);
      repeat (s > 0 ? s : 1) @(negedge clk);
    end
  end

  // Compare each transferred element against the oldest prediction
  always @(posedge clk) begin
    element_t exp_e, got;
    if (!rst && out_valid && !out_stall) begin
      got = '{element_value, element_index, is_global_best, saturated, last};
      if (pending_elems.size() == 0) begin
        $display("%0t: unexpected element, actual %h", $realtime, got);
        errors++;
      end else begin
        exp_e = pending_elems.pop_front();
        if (got !== exp_e) begin
          $display("%0t: mismatch, expected val=%h idx=%0d gb=%b sat=%b last=%b",
                   $realtime, exp_e.value, exp_e.index, exp_e.gb, exp_e.sat, exp_e.lst);
          $display("%0t:          actual   val=%h idx=%0d gb=%b sat=%b last=%b",
                   $realtime, got.value, got.index, got.gb, got.sat, got.lst);
          errors++;
        end
      end
    end
  end

  // Timeout watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > 600000) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic cmd_item_t mk(input logic [2:0] c, input int p, input int d,
                                   input logic [31:0] ps, input logic [31:0] cs,
                                   input logic [15:0] a, input logic [15:0] b);
    cmd_item_t it;
    it = '{c, p[4:0], d[3:0], ps, cs, a, b};
    return it;
  endfunction

  // Load every dimension of a particle
  task automatic load_particle(input int p, input bit extreme);
    logic [31:0] v;
    for (int d = 0; d < MaxDims; d++) begin
      v = extreme ? (($urandom_range(0, 1)) ? 32'h7FFFFFFF : 32'h80000000)
                  : ($urandom_range(0, 1) ? $urandom : 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19)));
      send_cmd(mk(CMD_LOAD, p, d, v, $urandom, 16'($urandom), 16'($urandom)), 1);
    end
  endtask

  initial begin
    typedef struct packed {
      cmd_item_t it;
      bit        chk;
      element_t  first_elem;
    } row_t;
    row_t rows [$];
    cmd_item_t it;
    int kind, p;
    element_t e;
    w_gain = 47775; c1_gain = 97940; c2_gain = 97940; dims_reg = 16;
    foreach (pbest_mem[i]) begin
      pbest_mem[i] = 0; pos_mem[i] = 0; vel_mem[i] = 0; loaded[i] = 0;
    end
    foreach (gbest[i]) gbest[i] = 0;
    foreach (pbest_cost[i]) pbest_cost[i] = 0;
    gbest_cost = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table: readout after reset shows zero global best
    rows.insert(rows.size(), row_t'{mk(CMD_READ, 0, 0, 0, 0, 0, 0), 1,
                                    '{0, 4'd0, 1'b1, 1'b0, 1'b0}});
    rows.insert(rows.size(), row_t'{mk(CMD_ORIGIN, 0, 0, 0, 32'h7FFFFFFF, 0, 0), 0, '0});
    rows.insert(rows.size(), row_t'{mk(CMD_LOAD, 0, 0, 32'h7FFFFFFF, 0, 0, 0), 0, '0});
    rows.insert(rows.size(), row_t'{mk(CMD_LOAD, 0, 15, 32'h80000000, 0, 0, 0), 0, '0});
    rows.insert(rows.size(), row_t'{mk(3'd5, 1, 0, 0, 0, 16'hFFFF, 16'hFFFF), 0, '0});
    rows.insert(rows.size(), row_t'{mk(3'd7, 31, 15, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0),
                                    0, '0});
    foreach (rows[r]) begin
      if (rows[r].chk) begin
        e = rows[r].first_elem;
        if (pending_elems.size() == 0) predict_swarm(rows[r].it);
      end
      // table entries with typed results check the first element directly
      if (rows[r].chk) begin
        if (pending_elems[0] !== e) begin
          $display("%0t: table row %0d expected %h predicted %h", $realtime, r, e,
                   pending_elems[0]);
          errors++;
        end
        it = rows[r].it;
        for (int k = 0; k < dims_active(); k++) void'(pending_elems.pop_back());
        send_cmd(it, 0);
      end else begin
        send_cmd(rows[r].it, 0);
      end
    end
    // Complete particles 0 and 31 with extremes, then move with max gains
    load_particle(0, 1);
    load_particle(31, 1);
    send_cmd(mk(CMD_REPORT, 0, 0, 0, 32'h80000000, 0, 0), 0);
    send_cmd(mk(CMD_MOVE, 31, 0, 0, 0, 16'hFFFF, 16'hFFFF), 0);
    send_cmd(mk(CMD_MOVE, 0, 0, 0, 0, 16'h0000, 16'h0000), 0);
    send_cmd(mk(CMD_READ, 0, 0, 0, 0, 0, 0), 0);
    set_reg(REG_INERTIA, 18'h3FFFF);
    set_reg(REG_COGNITIVE, 18'h3FFFF);
    set_reg(REG_SOCIAL, 18'h3FFFF);
    set_reg(REG_DIMS, 18'd1);
    send_cmd(mk(CMD_MOVE, 31, 0, 0, 0, 16'hFFFF, 16'hFFFF), 0);
    set_reg(REG_DIMS, 18'd0);
    send_cmd(mk(CMD_READ, 0, 0, 0, 0, 0, 0), 0);
    set_reg(REG_DIMS, 18'd31);
    send_cmd(mk(CMD_MOVE, 0, 0, 0, 0, 16'h8000, 16'h0001), 0);

    // Random phases with different register settings
    for (int ph = 0; ph < 4; ph++) begin
      set_reg(REG_INERTIA, ph == 0 ? 18'd0 : 18'($urandom_range(0, 70000)));
      set_reg(REG_COGNITIVE, 18'($urandom_range(0, 262143)));
      set_reg(REG_SOCIAL, 18'($urandom_range(0, 140000)));
      set_reg(REG_DIMS, ph == 1 ? 18'd16 : 18'($urandom_range(1, 16)));
      send_cmd(mk(CMD_ORIGIN, 0, 0, 0, $urandom, 0, 0), 1);
      for (int j = 0; j < 2; j++) begin
        p = $urandom_range(0, 31);
        load_particle(p, 0);
      end
      for (int i = 0; i < 35; i++) begin
        if (ph == 2 && i == 5) long_hold = 1;
        kind = $urandom_range(0, 9);
        p = $urandom_range(0, 31);
        while (!loaded[p*MaxDims]) p = $urandom_range(0, 31);
        for (int d = 1; d < MaxDims; d++) if (!loaded[p*MaxDims+d]) p = 0;
        case (kind)
          0, 1, 2, 3: it = mk(CMD_MOVE, p, 0, 0, 0, 16'($urandom), 16'($urandom));
          4, 5, 6:    it = mk(CMD_REPORT, p, 0, 0, $urandom, 0, 0);
          7:          it = mk(CMD_READ, p, $urandom, $urandom, $urandom, 0, 0);
          8:          it = mk(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom,
                              $urandom, 16'($urandom), 16'($urandom));
          default:    it = mk(CMD_LOAD, p, $urandom, $urandom, 0, 0, 0);
        endcase
        send_cmd(it, i % 13 > 2);
      end
    end
    in_valid <= 1'b0;

    while (pending_elems.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/psue_pkg.sv
design/particle_swarm_update_engine_top.sv
design/psue_checker.sv
dv/tb_top.sv
